### rtl/psd_pkg.sv
// Shared types and constants for the panel switch scan and debounce block.
// Holds the request and result structs, row codes and column assignments.
// No dependencies.
`timescale 1ns / 1ps

package psd_pkg;

    // Matrix geometry and field widths.
    localparam int NUM_COLUMNS         = 18;
    localparam int NUM_MOMENTARY_DEF   = 10;
    localparam int DEBOUNCE_RELOAD_DEF = 8;
    localparam int SWITCH_W            = 2 * NUM_COLUMNS;
    localparam int PRESSED_W           = 10;
    localparam int STOP_W              = 5;
    localparam int TOGGLE_W            = 9;
    localparam int RATE_W              = 4;
    localparam int COUNT_W             = 9;
    localparam int ROW_W               = 3;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_REPEAT_RATE = 1'b0;

    // Row codes.
    localparam logic [ROW_W-1:0] ROW_SW_LOW  = 3'd0;
    localparam logic [ROW_W-1:0] ROW_SW_HIGH = 3'd1;
    localparam logic [ROW_W-1:0] ROW_ADDR    = 3'd2;
    localparam logic [ROW_W-1:0] ROW_MOM     = 3'd3;
    localparam logic [ROW_W-1:0] ROW_TOGGLE  = 3'd4;

    // Toggle row column assignments.
    localparam int COL_REPEAT = 5;
    localparam int COL_NXM    = 6;
    localparam int COL_PARITY = 7;
    localparam int COL_SI_A   = 8;
    localparam int COL_SI_B   = 9;

    // Bit positions inside the latched toggle word.
    localparam int TGL_NXM    = 5;
    localparam int TGL_SI     = 6;
    localparam int TGL_PARITY = 7;
    localparam int TGL_REPEAT = 8;

    typedef struct packed {
        logic [ROW_W-1:0]       row;
        logic [NUM_COLUMNS-1:0] levels;
    } in_t;

    typedef struct packed {
        logic [SWITCH_W-1:0]    switch_word;
        logic [NUM_COLUMNS-1:0] address_switches;
        logic [STOP_W-1:0]      stop_conditions;
        logic                   nonexistent_memory_stop;
        logic                   single_instruction;
        logic                   parity_stop;
        logic                   repeat_enabled;
        logic [PRESSED_W-1:0]   pressed;
        logic                   frame_end;
    } out_t;

    // Per-request strobes shared by all debounce lanes.
    typedef struct packed {
        logic sample_en;
        logic frame_en;
        logic reload_all;
    } lane_ctl_t;

endpackage

### rtl/psd_lane.sv
// One debounce lane for a single momentary switch.
// Depends on psd_pkg for the lane control struct.
`timescale 1ns / 1ps

module psd_lane
    import psd_pkg::*;
#(
    parameter int DEBOUNCE_RELOAD = DEBOUNCE_RELOAD_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  lane_ctl_t ctl,
    input  logic      sample,
    output logic      pressed
);

    localparam int CNT_W = $clog2(DEBOUNCE_RELOAD + 1);

    logic             stable_reg, stable_next;
    logic             last_reg, last_next;
    logic             flag_reg, flag_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             flag_eff;

    // At frame end a repeat expiry forces the flag to the stable level.
    assign flag_eff = ctl.reload_all ? stable_reg : flag_reg;
    assign pressed  = ctl.frame_en & flag_eff & stable_reg;

    // Debounce on the momentary row, flag update at frame end.
    always_comb
    begin
        stable_next = stable_reg;
        last_next   = last_reg;
        flag_next   = flag_reg;
        count_next  = count_reg;
        if (ctl.sample_en)
        begin
            if (stable_reg == sample)
            begin
                if (count_reg != '0)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    if (last_reg != stable_reg)
                    begin
                        flag_next = 1'b1;
                    end
                    last_next = stable_reg;
                end
            end
            else
            begin
                count_next  = CNT_W'(DEBOUNCE_RELOAD);
                flag_next   = 1'b0;
                stable_next = sample;
            end
        end
        else if (ctl.frame_en)
        begin
            // A reported press clears its flag.
            flag_next = flag_eff & ~stable_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            last_reg   <= 1'b0;
            flag_reg   <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            stable_reg <= stable_next;
            last_reg   <= last_next;
            flag_reg   <= flag_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/psd_merge.sv
// Merges the lane press bits into the pressed mask and runs the repeat countdown.
// Depends on psd_pkg for widths.
`timescale 1ns / 1ps

module psd_merge
    import psd_pkg::*;
#(
    parameter int NUM_MOMENTARY = NUM_MOMENTARY_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     frame_en,
    input  logic                     repeat_on,
    input  logic [RATE_W-1:0]        repeat_rate,
    input  logic [NUM_MOMENTARY-1:0] lane_pressed,
    output logic                     reload_all,
    output logic [PRESSED_W-1:0]     pressed
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] reload_val;

    // The countdown reaching zero this frame re-arms every flag.
    assign reload_all = frame_en && (count_reg == COUNT_W'(1));
    assign reload_val = COUNT_W'((COUNT_W'(repeat_rate) + COUNT_W'(1)) << 4);

    // Reported mask carries the first PRESSED_W lanes.
    for (genvar k = 0; k < PRESSED_W; k++)
    begin : g_mask
        if (k < NUM_MOMENTARY)
        begin : g_lane
            assign pressed[k] = lane_pressed[k];
        end
        else
        begin : g_pad
            assign pressed[k] = 1'b0;
        end
    end

    // Countdown decrements each frame and reloads on a press with repeat on.
    always_comb
    begin
        count_next = count_reg;
        if (frame_en)
        begin
            if (count_reg != '0)
            begin
                count_next = count_reg - COUNT_W'(1);
            end
            if ((|lane_pressed) && repeat_on)
            begin
                count_next = reload_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

### rtl/panel_switch_scan_debounce.sv
// Top level of the panel switch scan, debounce and auto-repeat block.
// Depends on psd_pkg, psd_lane and psd_merge.
//
// Each request is one scanned row of an 18-column active-low switch matrix and
// yields exactly one result, registered in the cycle after it is taken; a new
// request can be taken every cycle. All momentary switches are debounced in
// parallel lanes, one per switch, and a merging stage builds the pressed mask
// and runs the repeat countdown, so throughput is set only by the single result
// register: one request per cycle while the result side keeps up. Rows 0 and 1
// load the switch word, row 2 the address switches, row 3 the debouncers and
// row 4 the toggles and the end of frame; rows 5 to 7 change nothing. The repeat
// rate register sits at byte address 0 and should be written while the block is idle.
`timescale 1ns / 1ps

module panel_switch_scan_debounce
    import psd_pkg::*;
#(
    parameter int NUM_MOMENTARY   = NUM_MOMENTARY_DEF,
    parameter int DEBOUNCE_RELOAD = DEBOUNCE_RELOAD_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [SWITCH_W-1:0]    switch_reg, switch_next;
    logic [NUM_COLUMNS-1:0] addr_sw_reg, addr_sw_next;
    logic [TOGGLE_W-1:0]    toggle_reg, toggle_next;
    logic [RATE_W-1:0]      rate_reg;
    out_t                   out_reg;
    logic                   out_valid_reg;

    logic                     accept;
    logic [NUM_COLUMNS-1:0]   closed;
    logic                     sample_en;
    logic                     frame_en;
    lane_ctl_t                lane_ctl;
    logic [NUM_MOMENTARY-1:0] lane_pressed;
    logic [PRESSED_W-1:0]     pressed;
    logic                     reload_all;
    logic                     reg_sel;
    out_t                     result;

    // Handshake: the result register frees up as its result is taken.
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign closed    = ~in_data.levels;

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign prdata  = (reg_sel == REG_REPEAT_RATE) ? APB_DATA_W'(rate_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (reg_sel == REG_REPEAT_RATE))
        begin
            rate_reg <= pwdata[RATE_W-1:0];
        end
    end

    // Row decode and panel register updates.
    always_comb
    begin
        switch_next  = switch_reg;
        addr_sw_next = addr_sw_reg;
        toggle_next  = toggle_reg;
        sample_en    = 1'b0;
        frame_en     = 1'b0;
        if (accept)
        begin
            case (in_data.row)
                ROW_SW_LOW:
                begin
                    switch_next[NUM_COLUMNS-1:0] = closed;
                end
                ROW_SW_HIGH:
                begin
                    switch_next[SWITCH_W-1:NUM_COLUMNS] = closed;
                end
                ROW_ADDR:
                begin
                    addr_sw_next = closed;
                end
                ROW_MOM:
                begin
                    sample_en = 1'b1;
                end
                ROW_TOGGLE:
                begin
                    frame_en = 1'b1;
                    for (int k = 0; k < STOP_W; k++)
                    begin
                        toggle_next[k] = closed[STOP_W-1-k];
                    end
                    toggle_next[TGL_NXM]    = closed[COL_NXM];
                    toggle_next[TGL_SI]     = closed[COL_SI_A] | closed[COL_SI_B];
                    toggle_next[TGL_PARITY] = closed[COL_PARITY];
                    toggle_next[TGL_REPEAT] = closed[COL_REPEAT];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Strobes shared by all lanes, in the order of the lane control struct.
    assign lane_ctl = {sample_en, frame_en, reload_all};

    // One debounce lane per momentary switch.
    for (genvar i = 0; i < NUM_MOMENTARY; i++)
    begin : g_lane
        psd_lane #(
            .DEBOUNCE_RELOAD(DEBOUNCE_RELOAD)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (lane_ctl),
            .sample (closed[i]),
            .pressed(lane_pressed[i])
        );
    end

    // Merge of lane results and repeat countdown.
    psd_merge #(
        .NUM_MOMENTARY(NUM_MOMENTARY)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_en    (frame_en),
        .repeat_on   (toggle_next[TGL_REPEAT]),
        .repeat_rate (rate_reg),
        .lane_pressed(lane_pressed),
        .reload_all  (reload_all),
        .pressed     (pressed)
    );

    // Result built from the updated panel state.
    always_comb
    begin
        result.switch_word             = switch_next;
        result.address_switches        = addr_sw_next;
        result.stop_conditions         = toggle_next[STOP_W-1:0];
        result.nonexistent_memory_stop = toggle_next[TGL_NXM];
        result.single_instruction      = toggle_next[TGL_SI];
        result.parity_stop             = toggle_next[TGL_PARITY];
        result.repeat_enabled          = toggle_next[TGL_REPEAT];
        result.pressed                 = pressed;
        result.frame_end               = frame_en;
    end

    // Panel state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_reg  <= '0;
            addr_sw_reg <= '0;
            toggle_reg  <= '0;
        end
        else
        begin
            switch_reg  <= switch_next;
            addr_sw_reg <= addr_sw_next;
            toggle_reg  <= toggle_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= result;
        end
    end

endmodule
